// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// a implies b in the same cycle
`define AST_IMPL(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
    else $error("assertion failed");
// a implies b in the next cycle
`define AST_NEXT(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
    else $error("assertion failed");
// a implies b in the next cycle, also checked during reset
`define AST_NEXT_NR(lbl, ck, a, b) \
  lbl: assert property (@(posedge ck) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ----- rtl/pads_pkg.sv -----
// types and constants of the diagonal smoother
// no dependencies
`default_nettype none
package pads_pkg;
  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_CALC, ST_BLEND} pads_state_t;

  localparam int WIN_TAPS = 9;
  localparam int WIN_CENTRE = 4;
  localparam logic [7:0] ALPHA_LIMIT = 8'd128;
  localparam logic [7:0] THIRD_MUL = 8'd171;
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic       accept;
    logic       rd_en;
    logic [3:0] rd_idx;
    logic       cap_en;
    logic [3:0] cap_idx;
    logic       calc;
    logic       load;
  } pads_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic out_free;
  } pads_stat_t;
endpackage
`default_nettype wire

// ----- rtl/pads_ram.sv -----
// generic simple dual port ram, registered read
// no dependencies
`default_nettype none
module pads_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2052
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/pads_ctrl.sv -----
// controller state machine of the smoother
// depends on pads_pkg
`default_nettype none
module pads_ctrl import pads_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire pads_stat_t stat,
  output pads_cmd_t       cmd
);
  pads_state_t state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.rd_idx  = step_r;
    cmd.cap_idx = step_r - 4'd1;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        step_nxt   = '0;
        if (in_tvalid && stat.emit_req) state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en  = (step_r < 4'(WIN_TAPS));
        cmd.cap_en = (step_r != 4'd0);
        step_nxt   = step_r + 4'd1;
        if (step_r == 4'(WIN_TAPS)) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_BLEND;
      end
      ST_BLEND: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/pads_dp.sv -----
// datapath: counters, row ring, window, match and blend, output register
// depends on pads_pkg and pads_ram
`default_nettype none
module pads_dp import pads_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic [31:0] in_tdata,
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,
  output logic             out_tlast,
  input  wire pads_cmd_t   cmd,
  output pads_stat_t       stat
);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = 2 * MAX_WIDTH + 4;
  localparam int AW = $clog2(DEPTH);

  logic [10:0]   width_r, height_r;
  logic [CW-1:0] w;
  logic [RW-1:0] h;
  logic [CW-1:0] in_col_r, out_col_r;
  logic [RW-1:0] in_row_r, out_row_r;
  logic [CW:0]   lag_r;
  logic [AW-1:0] wp_r, op_r;
  logic          in_done;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic          flag, flag_r;
  logic [31:0]   win_r [WIN_TAPS];
  logic [7:0]    s_r [4];
  logic          any_r;

  always_comb begin
    if (width_r == 11'd0) w = CW'(1);
    else if (32'(width_r) > MAX_WIDTH) w = CW'(MAX_WIDTH);
    else w = CW'(width_r);
    if (height_r == 11'd0) h = RW'(1);
    else if (32'(height_r) > MAX_HEIGHT) h = RW'(MAX_HEIGHT);
    else h = RW'(height_r);
  end

  assign in_done = (in_row_r == h);
  wire pixel = (in_tuser[0] == CMD_PIXEL);

  always_comb begin
    stat.out_free = !out_tvalid || out_tready;
    if (pixel) stat.emit_req = !in_done && ((lag_r + 1'b1) >= ((CW+1)'(w) + 2'd2));
    else stat.emit_req = in_done;
  end

  pads_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ring (
    .clk(clk), .we(cmd.accept && pixel && !in_done), .waddr(wp_r), .wdata(in_tdata),
    .re(cmd.rd_en), .raddr(raddr), .rdata(rdata)
  );

  // neighbor address and inside-frame flag for the tap being read
  always_comb begin
    logic [AW:0] t;
    logic [AW:0] wa;
    wa   = (AW+1)'(w);
    t    = {1'b0, op_r};
    flag = 1'b1;
    case (cmd.rd_idx)
      4'd0, 4'd1, 4'd2: begin
        t = t - wa;
        if (t[AW]) t = t + (AW+1)'(DEPTH);
        if (out_row_r == '0) flag = 1'b0;
      end
      4'd6, 4'd7, 4'd8: begin
        t = t + wa;
        if (t >= (AW+1)'(DEPTH)) t = t - (AW+1)'(DEPTH);
        if (32'(out_row_r) + 1 >= 32'(h)) flag = 1'b0;
      end
      default: ;
    endcase
    case (cmd.rd_idx)
      4'd0, 4'd3, 4'd6: begin
        if (t == '0) t = (AW+1)'(DEPTH - 1);
        else t = t - 1'b1;
        if (out_col_r == '0) flag = 1'b0;
      end
      4'd2, 4'd5, 4'd8: begin
        t = t + 1'b1;
        if (t == (AW+1)'(DEPTH)) t = '0;
        if (32'(out_col_r) + 1 >= 32'(w)) flag = 1'b0;
      end
      default: ;
    endcase
    raddr = t[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) flag_r <= flag;
    if (cmd.cap_en) win_r[cmd.cap_idx] <= flag_r ? rdata : 32'd0;
  end

  // diagonal matches, channel sums and division by four times the count
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      logic [9:0]  sum [4];
      logic [2:0]  n;
      logic [31:0] c;
      logic [7:0]  q;
      logic [15:0] p3;
      int          dx, dy;
      n = '0;
      for (int k = 0; k < 4; k++) sum[k] = '0;
      for (int i = 0; i < 4; i++) begin
        dx = (i < 2) ? -1 : 1;
        dy = (i % 2 == 0) ? -1 : 1;
        c  = win_r[WIN_CENTRE + dx];
        if (c[31:24] > ALPHA_LIMIT && c == win_r[(1 + dy) * 3 + 1] &&
            (c != win_r[(1 + dy) * 3 + 1 + dx] || c != win_r[(1 + dy) * 3 + 1 - dx] ||
             c != win_r[(1 - dy) * 3 + 1 + dx])) begin
          for (int k = 0; k < 4; k++) sum[k] = sum[k] + 10'(c[8*k +: 8]);
          n = n + 3'd1;
        end
      end
      any_r <= (n != 3'd0);
      for (int k = 0; k < 4; k++) begin
        q  = sum[k][9:2];
        p3 = 16'(q) * 16'(THIRD_MUL);
        case (n)
          3'd2:    s_r[k] <= q >> 1;
          3'd3:    s_r[k] <= 8'(p3 >> 9);
          3'd4:    s_r[k] <= q >> 2;
          default: s_r[k] <= q;
        endcase
      end
    end
  end

  // source-over blend of the averaged pixel onto the centre
  logic [31:0] blend;
  always_comb begin
    logic [8:0]  inv;
    logic [16:0] prod;
    logic [9:0]  v;
    inv = 9'd256 - (9'(s_r[3]) + 9'(s_r[3][7]));
    for (int k = 0; k < 4; k++) begin
      prod = 17'(inv) * 17'(win_r[WIN_CENTRE][8*k +: 8]);
      v    = 10'(s_r[k]) + 10'(prod[16:8]);
      blend[8*k +: 8] = (v > 10'd255) ? 8'd255 : v[7:0];
    end
    if (!any_r) blend = win_r[WIN_CENTRE];
  end

  wire last_col = (32'(out_col_r) + 1 >= 32'(w));
  wire last_pix = last_col && (32'(out_row_r) + 1 >= 32'(h));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_tdata <= blend;
      out_tlast <= last_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 11'd16;
      height_r   <= 11'd16;
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      lag_r      <= '0;
      wp_r       <= '0;
      op_r       <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (cmd.load) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) width_r <= cfg_wdata;
        else height_r <= cfg_wdata;
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        lag_r     <= '0;
        wp_r      <= '0;
        op_r      <= '0;
      end else if (cmd.accept && pixel && !in_done) begin
        lag_r <= lag_r + 1'b1;
        wp_r  <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
        if (32'(in_col_r) + 1 >= 32'(w)) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
      end else if (cmd.load) begin
        if (last_pix) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
          lag_r     <= '0;
          wp_r      <= '0;
          op_r      <= '0;
        end else begin
          lag_r <= lag_r - 1'b1;
          op_r  <= (op_r == AW'(DEPTH - 1)) ? '0 : op_r + 1'b1;
          if (last_col) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + 1'b1;
          end else begin
            out_col_r <= out_col_r + 1'b1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/pixel_art_diagonal_smoother.sv -----
// top level of the pixel art diagonal smoother
// depends on pads_pkg, pads_ctrl, pads_dp, pads_ram
//
// channel | direction | contents
// in_     | slave     | tdata rgba pixel, tuser command (0 pixel, 1 drain)
// out_    | master    | tdata smoothed rgba pixel, tlast frame done
// cfg_    | write     | index 0 image width, index 1 image height
//
// a request that causes no result is taken in the idle state, which the block stays in
// a request that causes a result goes through the accept, the nine reads
// through the single read port of the row ring, the match and the blend
// the output register frees the input side once the result is loaded
// reset is synchronous and clears counters and handshake state, no ring clearing
// a stalled output holds the block in its blend step until the result is taken
`default_nettype none
module pixel_art_diagonal_smoother import pads_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // in_red, in_green, in_blue, in_alpha
  input  wire logic [0:0]  in_tuser,   // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic             out_tlast   // frame_done
);
  pads_cmd_t  cmd;
  pads_stat_t stat;

  // sequencing of accept, window reads, match and blend
  pads_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat(stat), .cmd(cmd)
  );

  // counters, ring store, window and arithmetic
  pads_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .cmd(cmd), .stat(stat)
  );
endmodule
`default_nettype wire

// ----- rtl/pads_checker.sv -----
// port level checks of the smoother, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module pads_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast
);
  // a stalled result holds
  `AST_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  // no result straight out of reset
  `AST_NEXT_NR(a_rst_quiet, clk, !rst_n, !out_tvalid)
  // a new result is loaded only while the input side is busy
  `AST_IMPL(a_load_busy, clk, rst_n, $rose(out_tvalid), !$past(in_tready))
endmodule

bind pixel_art_diagonal_smoother pads_checker u_pads_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tlast(out_tlast)
);
`default_nettype wire

// ----- tb/smoother_checker.sv -----
// checker for the pixel art diagonal smoother: predicts every smoothed pixel
// from the accepted requests and compares it with the out_ channel
// depends on pads_pkg
module smoother_checker import pads_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  output int          pending,
  output int          failures
);
  localparam int RING = 2 * MAX_WIDTH + 4;

  typedef struct packed {
    logic [31:0] pixel;
    logic        last;
  } smooth_px_t;

  logic [31:0] history[RING];
  logic [31:0] win[9];
  int unsigned width_reg, height_reg;
  int unsigned icol, irow, ocol, orow;
  smooth_px_t  smooth_q[$];

  function automatic int unsigned clamp_size(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic logic [31:0] pick(int px, int py, int unsigned w, int unsigned h);
    if (px < 0 || py < 0 || px >= int'(w) || py >= int'(h)) return '0;
    return history[(py * w + px) % RING];
  endfunction

  // builds the window around the output position and blends
  task automatic smooth_next(input int unsigned w, input int unsigned h);
    int unsigned sum[4];
    int unsigned s[4];
    int unsigned n, sa, inv, v;
    logic [31:0] c, ctr;
    smooth_px_t  r;
    for (int k = 0; k < 4; k++) sum[k] = 0;
    n = 0;
    for (int dy = -1; dy <= 1; dy++)
      for (int dx = -1; dx <= 1; dx++)
        win[(dy + 1) * 3 + dx + 1] = pick(int'(ocol) + dx, int'(orow) + dy, w, h);
    for (int dx = -1; dx <= 1; dx += 2)
      for (int dy = -1; dy <= 1; dy += 2) begin
        c = win[4 + dx];
        if (c[31:24] > ALPHA_LIMIT && c == win[(1 + dy) * 3 + 1] &&
            (c != win[(1 + dy) * 3 + 1 + dx] || c != win[(1 + dy) * 3 + 1 - dx] ||
             c != win[(1 - dy) * 3 + 1 + dx])) begin
          for (int k = 0; k < 4; k++) sum[k] += c[8*k +: 8];
          n++;
        end
      end
    ctr = win[WIN_CENTRE];
    r.pixel = ctr;
    if (n != 0) begin
      for (int k = 0; k < 4; k++) s[k] = sum[k] / (4 * n);
      sa = s[3];
      inv = 256 - (sa + (sa >> 7));
      for (int k = 0; k < 4; k++) begin
        v = s[k] + ((inv * ctr[8*k +: 8]) >> 8);
        r.pixel[8*k +: 8] = (v > 255) ? 8'hff : v[7:0];
      end
    end
    r.last = 1'b0;
    ocol++;
    if (ocol >= w) begin
      ocol = 0;
      orow++;
    end
    if (orow >= h) begin
      r.last = 1'b1;
      icol = 0; irow = 0; ocol = 0; orow = 0;
    end
    smooth_q.push_back(r);
  endtask

  task automatic take_request(input logic cmd, input logic [31:0] px);
    int unsigned w, h, total, recv, o;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    total = w * h;
    recv = irow * w + icol;
    o = orow * w + ocol;
    if (cmd == CMD_PIXEL) begin
      if (recv < total) begin
        history[recv % RING] = px;
        icol++;
        if (icol >= w) begin
          icol = 0;
          irow++;
        end
        if (recv + 1 >= o + w + 2) smooth_next(w, h);
      end
    end else if (recv >= total) begin
      smooth_next(w, h);
    end
  endtask

  assign pending = smooth_q.size();

  always @(posedge clk) begin
    smooth_px_t e;
    if (!rst_n) begin
      for (int i = 0; i < RING; i++) history[i] = '0;
      width_reg = 16; height_reg = 16;
      icol = 0; irow = 0; ocol = 0; orow = 0;
      smooth_q.delete();
      failures = 0;
    end else begin
      // results first: one arriving now is never caused by this edge's request
      if (out_tvalid && out_tready) begin
        if (smooth_q.size() == 0) begin
          $display("%0t: unexpected result %h last %b", $time, out_tdata, out_tlast);
          failures++;
        end else begin
          e = smooth_q.pop_front();
          if (e.pixel !== out_tdata || e.last !== out_tlast) begin
            $display("%0t: expected %h last %b, actual %h last %b",
                     $time, e.pixel, e.last, out_tdata, out_tlast);
            failures++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) width_reg = cfg_wdata;
        else height_reg = cfg_wdata;
        icol = 0; irow = 0; ocol = 0; orow = 0;
      end
      if (in_tvalid && in_tready) take_request(in_tuser[0], in_tdata);
    end
  end
endmodule

// ----- tb/pixel_art_diagonal_smoother_test.sv -----
// testbench top of the pixel art diagonal smoother: drives frames of pixels,
// drain requests and size writes, and gives the verdict
// depends on pads_pkg, smoother_checker and the block itself
module pixel_art_diagonal_smoother_test import pads_pkg::*;;
  localparam int WATCH_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_WIDTH;
  logic [10:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // red, green, blue, alpha
  logic [0:0]  in_tuser = CMD_PIXEL;   // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // red, green, blue, alpha
  logic        out_tlast;       // frame done
  int          pending, failures;
  int          sent = 0;
  int          idle_cycles = 0;
  logic        allow_gaps = 1'b1;
  logic [31:0] palette[4];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pixel_art_diagonal_smoother i_dut (.*);

  smoother_checker i_checker (.*);

  // watchdog: cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("** pixel_art_diagonal_smoother: FAILED **");
      $finish;
    end
  end

  // receiver stalls: mostly short, a few long, with stall-free stretches
  initial begin
    int n;
    forever begin
      @(posedge clk);
      out_tready <= 1'b1;
      repeat ($urandom_range(0, 30)) @(posedge clk);
      if (allow_gaps && $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic int gap_len();
    if (!allow_gaps || $urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(6, 30);
    return $urandom_range(1, 2);
  endfunction

  // one request, then an optional gap
  task automatic send(input logic cmd, input logic [31:0] px);
    int g;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    sent++;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // pauses the sender until every result is back, then lets the block settle
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [10:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly palette colors so that neighbors repeat, some noise
  function automatic logic [31:0] rand_pixel();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return palette[$urandom_range(0, 3)];
  endfunction

  task automatic new_palette();
    logic [7:0] a;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 4))
        0: a = 8'd128;
        1: a = 8'd129;
        2: a = 8'hff;
        default: a = $urandom;
      endcase
      palette[i] = {a, 24'($urandom)};
    end
  endtask

  // full frame of random pixels then the drains that flush its tail
  task automatic random_frame(input int w, input int h);
    for (int i = 0; i < w * h; i++) send(CMD_PIXEL, rand_pixel());
    if ($urandom_range(0, 3) == 0) send(CMD_PIXEL, rand_pixel());  // ignored
    for (int i = 0; i < ((w * h < w + 1) ? w * h : w + 1); i++) send(CMD_DRAIN, $urandom);
  endtask

  initial begin
    logic [31:0] a, b;
    int w, h;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 3x3 frame with diagonal steps, extremes and ignored requests
    write_reg(REG_WIDTH, 11'd3);
    write_reg(REG_HEIGHT, 11'd3);
    a = 32'hff_80_40_20;
    b = 32'h81_ff_ff_ff;
    send(CMD_DRAIN, '0);               // drain before the frame is complete
    send(CMD_PIXEL, a);
    send(CMD_PIXEL, a);
    send(CMD_PIXEL, 32'h00000000);
    send(CMD_PIXEL, a);
    send(CMD_PIXEL, 32'hffffffff);     // saturating blend candidate
    send(CMD_PIXEL, b);
    send(CMD_PIXEL, 32'h80_ff_ff_ff);  // alpha at the threshold, not taken
    send(CMD_PIXEL, b);
    send(CMD_PIXEL, b);
    send(CMD_PIXEL, 32'hffffffff);     // after the frame: ignored
    for (int i = 0; i < 4; i++) send(CMD_DRAIN, 32'hffffffff);
    send(CMD_DRAIN, '0);               // frame restarted, ignored

    // size extremes: zero acts as one, oversize clamps to the maximum
    write_reg(REG_WIDTH, 11'd0);
    write_reg(REG_HEIGHT, 11'd0);
    new_palette();
    random_frame(1, 1);
    write_reg(REG_WIDTH, 11'h7ff);
    write_reg(REG_HEIGHT, 11'd2);
    for (int i = 0; i < 60; i++) send(CMD_PIXEL, rand_pixel());
    write_reg(REG_WIDTH, 11'd1);
    write_reg(REG_HEIGHT, 11'h7ff);
    for (int i = 0; i < 100; i++) send(CMD_PIXEL, rand_pixel());

    // frame aborted by a size write halfway
    write_reg(REG_WIDTH, 11'd5);
    write_reg(REG_HEIGHT, 11'd5);
    for (int i = 0; i < 13; i++) send(CMD_PIXEL, rand_pixel());

    // random frames of small sizes, some without any idling
    while (sent < 750) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      allow_gaps <= ($urandom_range(0, 3) != 0);
      write_reg(REG_WIDTH, 11'(w));
      write_reg(REG_HEIGHT, 11'(h));
      new_palette();
      random_frame(w, h);
    end

    settle();
    if (failures == 0) begin
      $display("** pixel_art_diagonal_smoother: PASSED **");
    end else begin
      $display("** pixel_art_diagonal_smoother: FAILED **");
    end
    $finish;
  end
endmodule
